// File: hw/rtl/pss_pkg.sv
// Shared types and constants for the positional sequence store.
package pss_pkg;

  localparam int POS_W        = 5;
  localparam int VAL_W        = 32;
  localparam int LEN_W        = 5;
  localparam int ACT_W        = 2;
  localparam int DEF_CAPACITY = 16;

  localparam logic [ACT_W-1:0] ACT_READ   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]        action;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value_in;
  } pss_in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value_out;
    logic [LEN_W-1:0]        length_now;
    logic                    error;
  } pss_out_t;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic             shift_up;
    logic             shift_down;
    logic [POS_W-1:0] pos;
  } pss_cmd_t;

endpackage

// File: hw/rtl/pss_cell.sv
// One storage cell of the sequence chain, holding a single entry.
module pss_cell #(
  parameter int INDEX = 0
) (
  input  logic                             clk,
  input  pss_pkg::pss_cmd_t                cmd,
  input  logic signed [pss_pkg::VAL_W-1:0] value_in,
  input  logic signed [pss_pkg::VAL_W-1:0] left_data,
  input  logic signed [pss_pkg::VAL_W-1:0] right_data,
  output logic signed [pss_pkg::VAL_W-1:0] data,
  output logic signed [pss_pkg::VAL_W-1:0] sel_data
);
  import pss_pkg::*;

  localparam logic [31:0] IDX = INDEX;

  logic signed [VAL_W-1:0] data_r;
  logic signed [VAL_W-1:0] data_nxt;
  logic [31:0]             pos_ext;
  logic                    at_pos;
  logic                    above_pos;

  assign pos_ext   = 32'(cmd.pos);
  assign at_pos    = (IDX == pos_ext);
  assign above_pos = (IDX > pos_ext);

  always_comb begin
    data_nxt = data_r;
    if (cmd.shift_up) begin
      if (above_pos) begin
        data_nxt = left_data;
      end else if (at_pos) begin
        data_nxt = value_in;
      end
    end else if (cmd.shift_down) begin
      if (above_pos || at_pos) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data     = data_r;
  // Only the addressed cell drives its entry onto the read OR tree.
  assign sel_data = at_pos ? data_r : '0;

endmodule

// File: hw/rtl/positional_sequence_store.sv
// Top level of the positional sequence store: cell chain, length counter and result register.
//
// Usage: requests arrive on the in_ channel as transactions carrying an action (read, insert
// or remove), a zero-based position and a value to insert. Each accepted transaction yields
// exactly one result transaction on the out_ channel carrying the value read or removed, the
// length of the sequence after the request and an error flag. A refused request (position
// out of range, insert into a full store, or an unused action code) returns zero with the
// error flag set and leaves the stored sequence untouched.
// The result is registered at the edge that accepts the request.
// Throughput is one request per cycle while the receiver does not stall. Each entry lives in
// its own cell; on an insert or remove every cell at or above the position loads the new
// value or its left or right neighbour at the same edge, so the sequence shifts as a whole.
// When the receiver stalls, the held result stays on the out_ port and in_stall is raised
// only while that result cannot leave; a new request is taken in the same cycle the held
// result is taken.
// Reset empties the sequence (length zero) and clears the output valid. Entry contents are
// not reset; only entries below the length are ever read.
module positional_sequence_store #(
  parameter int CAPACITY = pss_pkg::DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  pss_pkg::pss_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output pss_pkg::pss_out_t out_data
);
  import pss_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [31:0] CAP32 = CAPACITY;

  // Length of the sequence.
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;

  // Result register.
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  pss_out_t                out_data_r;
  pss_out_t                out_data_nxt;

  logic                    in_accept;
  logic [31:0]             pos_ext;
  logic [31:0]             cnt_ext;
  logic [31:0]             cnt_nxt_ext;
  logic                    in_range;
  logic                    room_ok;
  logic                    read_ok;
  logic                    insert_ok;
  logic                    remove_ok;
  logic                    req_ok;
  pss_cmd_t                cmd;
  logic signed [VAL_W-1:0] rd_data;

  logic signed [VAL_W-1:0] cell_q   [CAPACITY];
  logic signed [VAL_W-1:0] cell_sel [CAPACITY];

  // A new request may enter whenever the result register is empty or being emptied.
  assign in_stall  = out_valid_r && out_stall;
  assign in_accept = in_valid && !in_stall;

  // Range checks on the request, done at 32 bits so any capacity compares correctly.
  assign pos_ext  = 32'(in_data.position);
  assign cnt_ext  = 32'(count_r);
  assign in_range = (pos_ext < cnt_ext);
  assign room_ok  = (pos_ext <= cnt_ext) && (cnt_ext < CAP32);

  assign read_ok   = (in_data.action == ACT_READ)   && in_range;
  assign insert_ok = (in_data.action == ACT_INSERT) && room_ok;
  assign remove_ok = (in_data.action == ACT_REMOVE) && in_range;
  assign req_ok    = read_ok || insert_ok || remove_ok;

  assign cmd.shift_up   = in_accept && insert_ok;
  assign cmd.shift_down = in_accept && remove_ok;
  assign cmd.pos        = in_data.position;

  // The chain itself: the left input of cell zero is the new value from the request, and the
  // last cell takes zero from beyond the end on a remove.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = in_data.value_in;
    end else begin : g_inner_l
      assign left_d = cell_q[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner_r
      assign right_d = cell_q[i+1];
    end

    pss_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .value_in   (in_data.value_in),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_q[i]),
      .sel_data   (cell_sel[i])
    );
  end

  // At most one cell is addressed, so the read value is the OR of all masked cell outputs.
  always_comb begin
    rd_data = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_data = rd_data | cell_sel[k];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.shift_up) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.shift_down) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  assign cnt_nxt_ext = 32'(count_nxt);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (in_accept) begin
      out_valid_nxt           = 1'b1;
      out_data_nxt.value_out  = (read_ok || remove_ok) ? rd_data : '0;
      out_data_nxt.length_now = cnt_nxt_ext[LEN_W-1:0];
      out_data_nxt.error      = !req_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The length never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_ext <= CAP32)
    else $error("sequence length exceeds capacity");

  // A refused request reports a zero value.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.error) |-> (out_data_r.value_out == '0))
    else $error("refused request returned a non-zero value");

  // A refused request leaves the length unchanged.
  a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !req_ok) |=> (count_r == $past(count_r)))
    else $error("refused request changed the length");

  // An accepted insert grows the sequence by one.
  a_ins_len: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && insert_ok) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the length by one");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for the positional sequence store: scoreboard class, drivers and top.
`timescale 1ns / 100ps

// Keeps a copy of the stored sequence, works out the answer to each accepted request and
// compares the answers that come back from the block, oldest first.
class store_scoreboard;
  logic signed [pss_pkg::VAL_W-1:0] mirror_entries [pss_pkg::DEF_CAPACITY];
  int unsigned                      mirror_length;
  pss_pkg::pss_out_t                pending_answers [$];
  int                               mismatches;

  function new();
    mirror_length = 0;
    mismatches    = 0;
  endfunction

  // One line per mismatch; the count decides the final verdict.
  task report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Applies an accepted request to the copy and queues the answer it must produce.
  task note_request(input pss_pkg::pss_in_t req);
    pss_pkg::pss_out_t answer;
    int unsigned       pos;
    int unsigned       i;
    answer = '0;
    pos    = req.position;
    case (req.action)
      pss_pkg::ACT_READ: begin
        if (pos < mirror_length) begin
          answer.value_out = mirror_entries[pos];
        end else begin
          answer.error = 1'b1;
        end
      end
      pss_pkg::ACT_INSERT: begin
        if (pos <= mirror_length && mirror_length < pss_pkg::DEF_CAPACITY) begin
          for (i = mirror_length; i > pos; i--) begin
            mirror_entries[i] = mirror_entries[i-1];
          end
          mirror_entries[pos] = req.value_in;
          mirror_length++;
        end else begin
          answer.error = 1'b1;
        end
      end
      pss_pkg::ACT_REMOVE: begin
        if (pos < mirror_length) begin
          answer.value_out = mirror_entries[pos];
          for (i = pos; i + 1 < mirror_length; i++) begin
            mirror_entries[i] = mirror_entries[i+1];
          end
          mirror_length--;
        end else begin
          answer.error = 1'b1;
        end
      end
      default: begin
        answer.error = 1'b1;
      end
    endcase
    answer.length_now = mirror_length[pss_pkg::LEN_W-1:0];
    pending_answers.push_back(answer);
  endtask

  // Compares one accepted answer transaction with the oldest one still owed.
  task check_answer(input pss_pkg::pss_out_t got);
    pss_pkg::pss_out_t owed;
    if (pending_answers.size() == 0) begin
      report_mismatch("answer arrived with no request outstanding");
    end else begin
      owed = pending_answers.pop_front();
      if (got.value_out !== owed.value_out) begin
        report_mismatch($sformatf("value_out %0d, expected %0d", got.value_out, owed.value_out));
      end
      if (got.length_now !== owed.length_now) begin
        report_mismatch($sformatf("length_now %0d, expected %0d",
                                  got.length_now, owed.length_now));
      end
      if (got.error !== owed.error) begin
        report_mismatch($sformatf("error %b, expected %b", got.error, owed.error));
      end
    end
  endtask
endclass

module testbench;
  import pss_pkg::*;

  localparam int STORE_DEPTH   = DEF_CAPACITY;
  localparam int RANDOM_ITEMS  = 1300;
  // Worst honest wait between two transactions is a sender gap plus a receiver stall plus
  // the result register; the limit allows many times that.
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 10;
  // The one action code that the block does not define.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pss_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pss_out_t out_data;

  store_scoreboard board;
  bit              sender_calm;
  int unsigned     answers_taken;
  int unsigned     idle_cycles;

  positional_sequence_store #(
    .CAPACITY(STORE_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
  end

  always #10 clk = ~clk;

  // Drives one request transaction. Inputs change on the falling edge; acceptance is judged
  // from the values seen just before the rising edge. Once the transaction is taken the
  // scoreboard learns of it at that same edge, so the next request can be shaped around the
  // length it leaves behind.
  task automatic send_request(input pss_in_t req);
    int unsigned gap;
    gap = sender_calm ? 0 : $urandom_range(0, 19);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_request(req);
  endtask

  // Builds one request and sends it; used by the directed part.
  task automatic send_fields(input logic [ACT_W-1:0] action, input int unsigned position,
                             input logic signed [VAL_W-1:0] value);
    pss_in_t req;
    req.action   = action;
    req.position = position[POS_W-1:0];
    req.value_in = value;
    send_request(req);
  endtask

  // Random request. Most are well formed, with positions inside the current sequence so
  // that reads, inserts and removes reach every depth; the rest is noise over the whole
  // field ranges, including the unused action code and positions far beyond the end.
  // While growing, inserts dominate so the store fills up; otherwise removes drain it.
  function automatic pss_in_t next_request(input bit growing);
    pss_in_t     req;
    int unsigned len;
    int unsigned roll;
    len = board.mirror_length;
    case ($urandom_range(0, 9))
      0:       req.value_in = 32'sh7fff_ffff;
      1:       req.value_in = 32'sh8000_0000;
      default: req.value_in = $urandom;
    endcase
    if ($urandom_range(0, 99) < 12) begin
      req.action   = ACT_W'($urandom_range(0, 3));
      req.position = POS_W'($urandom_range(0, 31));
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        req.action = ACT_READ;
      end else if (roll < (growing ? 72 : 40)) begin
        req.action = ACT_INSERT;
      end else begin
        req.action = ACT_REMOVE;
      end
      if (req.action == ACT_INSERT) begin
        req.position = POS_W'($urandom_range(0, len));
      end else begin
        req.position = (len != 0) ? POS_W'($urandom_range(0, len - 1)) : '0;
      end
    end
    return req;
  endfunction

  // Receiver: before each answer it draws a stall, then takes the next valid transaction.
  // Every third stretch of forty answers runs with no stall at all.
  initial begin
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      int unsigned hold;
      hold = (((answers_taken / 40) % 3) == 1) ? 0 : $urandom_range(0, 19);
      @(negedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      board.check_answer(out_data);
      answers_taken++;
    end
  end

  // Watchdog: any stretch without a single accepted transaction on either channel that
  // reaches the limit means the block has hung.
  always @(posedge clk) begin
    if ((in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    board         = new();
    answers_taken = 0;
    idle_cycles   = 0;
    sender_calm   = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. On the empty store every read and remove is refused, as are an insert
    // beyond the end and the unused action code.
    send_fields(ACT_READ, 0, 32'sd5);
    send_fields(ACT_REMOVE, 0, 32'sd0);
    send_fields(ACT_INSERT, 1, 32'sd9);
    send_fields(ACT_UNUSED, 31, 32'sh7fff_ffff);
    // Extreme values: append into the empty store, prepend, then a middle insert.
    send_fields(ACT_INSERT, 0, 32'sh7fff_ffff);
    send_fields(ACT_INSERT, 0, 32'sh8000_0000);
    send_fields(ACT_INSERT, 1, -32'sd1);
    // Fill the store to capacity, alternating appends and prepends.
    for (n = 3; n < STORE_DEPTH; n++) begin
      send_fields(ACT_INSERT, (n % 2 == 0) ? n : 0, $urandom);
    end
    // A full store refuses inserts even at valid positions.
    send_fields(ACT_INSERT, STORE_DEPTH, 32'sd1);
    send_fields(ACT_INSERT, 0, 32'sd1);
    // Reads at the last entry, just past it and far past it.
    send_fields(ACT_READ, STORE_DEPTH - 1, 32'sd0);
    send_fields(ACT_READ, STORE_DEPTH, 32'sd0);
    send_fields(ACT_READ, 31, 32'sd0);
    // Remove the last entry, the first and one from the middle.
    send_fields(ACT_REMOVE, STORE_DEPTH - 1, 32'sd0);
    send_fields(ACT_REMOVE, 0, 32'sd0);
    send_fields(ACT_REMOVE, 6, 32'sd0);

    // Random part, in alternating fill and drain phases, with back-to-back stretches.
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      sender_calm = ((n / 50) % 3) == 0;
      send_request(next_request(((n / 120) % 2) == 0));
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Wait for every owed answer, then a settling stretch to catch any spurious one.
    while (board.pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pss_pkg.sv
hw/rtl/pss_cell.sv
hw/rtl/positional_sequence_store.sv
dv/testbench.sv
